>>> hw/rtl/dsc_pkg.sv
package dsc_pkg;

	localparam int unsigned MAX_PATH_EDGES_DEF = 1024;

	localparam int unsigned EDGE_W   = 46;
	localparam int unsigned COST_W   = 32;
	localparam int unsigned FACTOR_W = 10;
	localparam int unsigned IN_DATA_W  = 112;
	localparam int unsigned OUT_DATA_W = 64;
	localparam int unsigned OUT_USER_W = 3;

	localparam logic [FACTOR_W-1:0] DETOUR_FACTOR_RST = 10'd512;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT,
		VERDICT_SUPERPATH,
		VERDICT_TOO_LONG,
		VERDICT_OVERFLOW
	} verdict_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_FWD_RD,
		ST_FWD_CMP,
		ST_DECIDE,
		ST_BWD_RD,
		ST_BWD_CMP,
		ST_COST_A,
		ST_COST_B,
		ST_COST_C,
		ST_MUL,
		ST_CMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic chk_init;
		logic f_inc;
		logic decide;
		logic bwd_sel;
		logic bwd_dec;
		logic cost_b;
		logic cost_c;
		logic mul;
		logic cmp;
		logic out_load;
	} dsc_cmd_t;

	typedef struct packed {
		logic ovf;
		logic fwd_more;
		logic edge_eq;
		logic f_ne_n1;
		logic f_ne_n2;
		logic bwd_more;
		logic test_en;
		logic out_free;
	} dsc_status_t;

endpackage

>>> hw/rtl/dsc_ctrl.sv
module dsc_ctrl
	import dsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tuser,
	input  logic        s_tlast,
	output logic        s_tready,
	input  dsc_status_t status,
	output dsc_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
				if (s_tvalid && s_tuser && s_tlast) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				cmd.chk_init = 1'b1;
				state_d = status.ovf ? ST_DONE : ST_FWD_RD;
			end
			ST_FWD_RD: begin
				state_d = status.fwd_more ? ST_FWD_CMP : ST_DECIDE;
			end
			ST_FWD_CMP: begin
				if (status.edge_eq) begin
					cmd.f_inc = 1'b1;
					state_d = ST_FWD_RD;
				end else begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				if (status.f_ne_n1 && status.f_ne_n2) begin
					state_d = ST_BWD_RD;
				end else if (status.f_ne_n1 || status.f_ne_n2) begin
					state_d = ST_COST_A;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_BWD_RD: begin
				cmd.bwd_sel = 1'b1;
				state_d = status.bwd_more ? ST_BWD_CMP : ST_COST_A;
			end
			ST_BWD_CMP: begin
				if (status.edge_eq) begin
					cmd.bwd_dec = 1'b1;
					state_d = ST_BWD_RD;
				end else begin
					state_d = ST_COST_A;
				end
			end
			ST_COST_A: begin
				state_d = ST_COST_B;
			end
			ST_COST_B: begin
				cmd.cost_b = 1'b1;
				state_d = ST_COST_C;
			end
			ST_COST_C: begin
				cmd.cost_c = 1'b1;
				state_d = status.test_en ? ST_MUL : ST_DONE;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hw/rtl/dsc_datapath.sv
module dsc_datapath
	import dsc_pkg::*;
#(
	parameter int unsigned MAX_PATH_EDGES = MAX_PATH_EDGES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tuser,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tlast,
	input  logic                  cfg_wr,
	input  logic [FACTOR_W-1:0]   cfg_data,
	input  dsc_cmd_t              cmd,
	output dsc_status_t           status,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [OUT_USER_W-1:0] m_tuser
);

	localparam int unsigned AW = (MAX_PATH_EDGES > 1) ? $clog2(MAX_PATH_EDGES) : 1;
	localparam int unsigned CW = $clog2(MAX_PATH_EDGES + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PATH_EDGES);
	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	logic [EDGE_W-1:0] opt_edge_mem  [MAX_PATH_EDGES];
	logic [COST_W-1:0] opt_el_mem    [MAX_PATH_EDGES];
	logic [COST_W-1:0] opt_tr_mem    [MAX_PATH_EDGES];
	logic [EDGE_W-1:0] cand_edge_mem [MAX_PATH_EDGES];
	logic [COST_W-1:0] cand_el_mem   [MAX_PATH_EDGES];
	logic [COST_W-1:0] cand_tr_mem   [MAX_PATH_EDGES];

	logic [EDGE_W-1:0] in_edge;
	logic [COST_W-1:0] in_el;
	logic [COST_W-1:0] in_tr;

	logic [FACTOR_W-1:0] factor_q;
	logic [CW-1:0] opt_count_q;
	logic          opt_closed_q;
	logic          opt_ovf_q;
	logic [CW-1:0] cand_count_q;
	logic          cand_ovf_q;
	logic          m_valid_q;

	logic [CW-1:0] opt_eff;
	logic          opt_full;
	logic          cand_full;
	logic          opt_we;
	logic          cand_we;

	logic [CW-1:0] f_q;
	logic [AW-1:0] l1_q;
	logic [AW-1:0] l2_q;
	logic [CW-1:0] n1m1;
	logic [CW-1:0] n2m1;
	logic [CW-1:0] fm1;
	logic          opt_en_q;
	logic          cand_en_q;
	verdict_t      verdict_q;

	logic [AW-1:0] opt_edge_ra;
	logic [AW-1:0] cand_edge_ra;
	logic [AW-1:0] opt_el_ra;
	logic [AW-1:0] cand_el_ra;

	logic [EDGE_W-1:0] opt_edge_rd_q;
	logic [EDGE_W-1:0] cand_edge_rd_q;
	logic [COST_W-1:0] opt_el_rd_q;
	logic [COST_W-1:0] cand_el_rd_q;
	logic [COST_W-1:0] opt_tr_rd_q;
	logic [COST_W-1:0] cand_tr_rd_q;

	logic signed [COST_W:0]   opt_diff_q;
	logic signed [COST_W:0]   cand_diff_q;
	logic [COST_W-1:0]        opt_prev;
	logic [COST_W-1:0]        cand_prev;
	logic signed [COST_W+1:0] opt_res;
	logic signed [COST_W+1:0] cand_res;
	logic [COST_W-1:0]        optc_q;
	logic [COST_W-1:0]        candc_q;
	logic [FACTOR_W+COST_W-1:0] prod_q;

	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	assign in_edge = s_tdata[EDGE_W-1:0];
	assign in_el   = s_tdata[EDGE_W+COST_W-1:EDGE_W];
	assign in_tr   = s_tdata[EDGE_W+2*COST_W-1:EDGE_W+COST_W];

	assign opt_eff   = opt_closed_q ? '0 : opt_count_q;
	assign opt_full  = (opt_eff >= CNT_MAX);
	assign cand_full = (cand_count_q >= CNT_MAX);
	assign opt_we    = cmd.load && !s_tuser && !opt_full;
	assign cand_we   = cmd.load && s_tuser && !cand_full;

	assign n1m1 = opt_count_q - CNT_ONE;
	assign n2m1 = cand_count_q - CNT_ONE;
	assign fm1  = f_q - CNT_ONE;

	assign opt_edge_ra  = cmd.bwd_sel ? l1_q : f_q[AW-1:0];
	assign cand_edge_ra = cmd.bwd_sel ? l2_q : f_q[AW-1:0];
	assign opt_el_ra    = cmd.cost_b ? fm1[AW-1:0] : l1_q;
	assign cand_el_ra   = cmd.cost_b ? fm1[AW-1:0] : l2_q;

	always_ff @(posedge clk) begin
		if (opt_we) begin
			opt_edge_mem[opt_eff[AW-1:0]] <= in_edge;
			opt_el_mem[opt_eff[AW-1:0]]   <= in_el;
			opt_tr_mem[opt_eff[AW-1:0]]   <= in_tr;
		end
		opt_edge_rd_q <= opt_edge_mem[opt_edge_ra];
		opt_el_rd_q   <= opt_el_mem[opt_el_ra];
		opt_tr_rd_q   <= opt_tr_mem[f_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cand_we) begin
			cand_edge_mem[cand_count_q[AW-1:0]] <= in_edge;
			cand_el_mem[cand_count_q[AW-1:0]]   <= in_el;
			cand_tr_mem[cand_count_q[AW-1:0]]   <= in_tr;
		end
		cand_edge_rd_q <= cand_edge_mem[cand_edge_ra];
		cand_el_rd_q   <= cand_el_mem[cand_el_ra];
		cand_tr_rd_q   <= cand_tr_mem[f_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q     <= DETOUR_FACTOR_RST;
			opt_count_q  <= '0;
			opt_closed_q <= 1'b0;
			opt_ovf_q    <= 1'b0;
			cand_count_q <= '0;
			cand_ovf_q   <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr) begin
				factor_q <= cfg_data;
			end
			if (cmd.load && !s_tuser) begin
				opt_count_q  <= opt_full ? opt_eff : opt_eff + CNT_ONE;
				opt_ovf_q    <= opt_full || (opt_ovf_q && !opt_closed_q);
				opt_closed_q <= s_tlast;
			end
			if (cmd.load && s_tuser) begin
				if (cand_full) begin
					cand_ovf_q <= 1'b1;
				end else begin
					cand_count_q <= cand_count_q + CNT_ONE;
				end
			end
			if (cmd.out_load) begin
				cand_count_q <= '0;
				cand_ovf_q   <= 1'b0;
				m_valid_q    <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign opt_prev  = (f_q == '0) ? '0 : opt_el_rd_q;
	assign cand_prev = (f_q == '0) ? '0 : cand_el_rd_q;
	assign opt_res   = $signed({opt_diff_q[COST_W], opt_diff_q})
	                 - $signed({2'b00, opt_prev});
	assign cand_res  = $signed({cand_diff_q[COST_W], cand_diff_q})
	                 - $signed({2'b00, cand_prev});

	always_ff @(posedge clk) begin
		if (cmd.chk_init) begin
			f_q       <= '0;
			optc_q    <= '0;
			candc_q   <= '0;
			verdict_q <= (opt_ovf_q || cand_ovf_q) ? VERDICT_OVERFLOW : VERDICT_ACCEPT;
		end
		if (cmd.f_inc) begin
			f_q <= f_q + CNT_ONE;
		end
		if (cmd.decide) begin
			opt_en_q  <= (f_q != opt_count_q);
			cand_en_q <= (f_q != cand_count_q);
			l1_q      <= n1m1[AW-1:0];
			l2_q      <= n2m1[AW-1:0];
			if ((f_q == opt_count_q) && (f_q != cand_count_q)) begin
				verdict_q <= VERDICT_SUPERPATH;
			end
		end
		if (cmd.bwd_dec) begin
			l1_q <= l1_q - AW'(1);
			l2_q <= l2_q - AW'(1);
		end
		if (cmd.cost_b) begin
			opt_diff_q  <= $signed({1'b0, opt_el_rd_q}) - $signed({1'b0, opt_tr_rd_q});
			cand_diff_q <= $signed({1'b0, cand_el_rd_q}) - $signed({1'b0, cand_tr_rd_q});
		end
		if (cmd.cost_c) begin
			if (opt_en_q) begin
				optc_q <= opt_res[COST_W+1] ? '0 : opt_res[COST_W-1:0];
			end
			if (cand_en_q) begin
				candc_q <= cand_res[COST_W+1] ? '0 : cand_res[COST_W-1:0];
			end
		end
		if (cmd.mul) begin
			prod_q <= (FACTOR_W+COST_W)'(factor_q) * (FACTOR_W+COST_W)'(optc_q);
		end
		if (cmd.cmp) begin
			verdict_q <= (prod_q < {2'b00, candc_q, 8'h00}) ? VERDICT_TOO_LONG
			                                               : VERDICT_ACCEPT;
		end
		if (cmd.out_load) begin
			out_data_q <= {candc_q, optc_q};
			out_user_q <= {verdict_q, verdict_q == VERDICT_ACCEPT};
		end
	end

	assign status.ovf      = opt_ovf_q || cand_ovf_q;
	assign status.fwd_more = (f_q < opt_count_q) && (f_q < cand_count_q);
	assign status.edge_eq  = (opt_edge_rd_q == cand_edge_rd_q);
	assign status.f_ne_n1  = (f_q != opt_count_q);
	assign status.f_ne_n2  = (f_q != cand_count_q);
	assign status.bwd_more = (CW'(l1_q) > f_q) && (CW'(l2_q) > f_q);
	assign status.test_en  = opt_en_q;
	assign status.out_free = !m_valid_q || m_tready;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

>>> hw/rtl/detour_stretch_check.sv
// Local stretch test for an alternative route.
// The slave stream carries path edges: tuser selects the optimal path (0) or
// the candidate path (1), tlast ends a path, and tdata holds the edge id,
// the elapsed cost and the transition cost. Edges load at one per cycle while
// the block is idle. An optimal edge after a closed optimal path starts a new
// optimal path. The transfer of a candidate's last edge starts a check, during
// which tready is low: a start state, a forward scan over matching edges, a
// decision, a backward scan over matching edges, the segment cost states, the
// detour compare and the result load. Overflow, or both paths ending in the
// forward scan, leads straight to the result load; the backward scan runs
// only if neither path does, the compare only if the optimal path does not.
// Each check gives one transfer on the master stream: tuser holds the
// accept flag and the verdict, tdata the two detour costs. The result sits
// in an output register, so a stalled receiver blocks the block only when a
// second check finishes before the first result is taken.
// The detour factor is to be written through the cfg channel only while the
// block is idle; the block itself does not enforce this. Reset sets it to 2.0
// and empties both paths. Path stores need no clearing after reset.
module detour_stretch_check
	import dsc_pkg::*;
#(
	parameter int unsigned MAX_PATH_EDGES = MAX_PATH_EDGES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata, // edge id, cumulative cost, entry cost
	input  logic                  s_tuser, // req_type
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata, // optimal_detour_cost, candidate_detour_cost
	output logic [OUT_USER_W-1:0] m_tuser, // accepted, verdict
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [FACTOR_W-1:0]   cfg_data
);

	dsc_cmd_t    cmd;
	dsc_status_t status;

	assign cfg_ready = 1'b1;
	assign m_tlast   = 1'b1;

	dsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	dsc_datapath #(
		.MAX_PATH_EDGES (MAX_PATH_EDGES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
